// ----- design/stream_search_and_replace_defines.svh -----
// Assertion macros shared by the checker of the search-and-replace block.
`ifndef STREAM_SEARCH_AND_REPLACE_DEFINES_SVH
`define STREAM_SEARCH_AND_REPLACE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_search_and_replace: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_search_and_replace: next-cycle check failed");

`endif

// ----- design/ssr_pkg.sv -----
package ssr_pkg;

    // Fixed field and register widths.
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Default sizing of the pattern window and the replacement text.
    localparam int DEF_MAX_SEARCH_LEN  = 8;
    localparam int DEF_MAX_REPLACE_LEN = 8;

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_SEARCH_BYTES  = '0;
    localparam logic [LEN_W-1:0] RST_SEARCH_LEN    = LEN_W'(1);
    localparam logic [CFG_W-1:0] RST_REPLACE_BYTES = '0;
    localparam logic [LEN_W-1:0] RST_REPLACE_LEN   = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_BYTES  = 2'd0,
        CFG_SEARCH_LEN    = 2'd1,
        CFG_REPLACE_BYTES = 2'd2,
        CFG_REPLACE_LEN   = 2'd3
    } t_cfg_idx;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              string_done;
    } t_res;

endpackage

// ----- design/ssr_in_if.sv -----
interface ssr_in_if;
    logic                           valid;
    logic                           ready;
    logic [ssr_pkg::BYTE_W-1:0]     text_byte;
    logic                           final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- design/ssr_out_if.sv -----
interface ssr_out_if;
    logic                           valid;
    logic                           ready;
    logic [ssr_pkg::BYTE_W-1:0]     out_byte;
    logic                           byte_valid;
    logic                           string_done;

    modport source (output valid, output out_byte, output byte_valid, output string_done,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                    output ready);
endinterface

// ----- design/ssr_cell.sv -----
// One window position: holds a byte, takes the incoming byte when it is the write
// position, compares against its pattern byte and slides toward the head on a miss.
module ssr_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_wr,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_text_byte,
    input  logic                        i_shift,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_next_byte,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_pat_byte,
    output logic [ssr_pkg::BYTE_W-1:0]  o_new_byte,
    output logic                        o_match
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // Window content as seen after the incoming byte is written.
    assign o_new_byte = i_wr ? i_text_byte : r_byte;
    assign o_match    = (o_new_byte == i_pat_byte);

    // On a miss the window slides by one toward the oldest position.
    assign n_byte = i_shift ? i_next_byte : o_new_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= n_byte;
        end
    end
endmodule

// ----- design/ssr_out_queue.sv -----
// Shifting result queue. Each slot is a cell that either holds, takes its
// upstream neighbor on a pop, or loads one entry of a new burst. Slot 0 is the
// registered output.
module ssr_out_queue #(
    parameter int BURST = ssr_pkg::DEF_MAX_SEARCH_LEN,
    parameter int DEPTH = 2 * ssr_pkg::DEF_MAX_SEARCH_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [$clog2(DEPTH+1)-1:0]      i_push_cnt,
    input  ssr_pkg::t_res [BURST-1:0]       i_burst,
    output logic                            o_room,
    output logic                            o_valid,
    output ssr_pkg::t_res                   o_item,
    input  logic                            i_pop_ready
);
    import ssr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    t_res          r_cell [DEPTH];
    t_res          n_cell [DEPTH];
    logic          pop;
    logic [CW-1:0] base;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_cell[0];
    assign pop     = o_valid & i_pop_ready;
    assign base    = r_cnt - CW'(pop);
    // A whole burst must fit, so a new item is taken only with room for the largest one.
    assign o_room  = (r_cnt <= CW'(DEPTH - BURST));

    assign n_cnt = base + (i_push ? i_push_cnt : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        t_res upstream;

        if (k == DEPTH - 1) begin : g_last
            assign upstream = r_cell[k];
        end else begin : g_mid
            assign upstream = r_cell[k+1];
        end

        // Occupied slots move up on a pop; free slots take burst entries in order.
        always_comb begin
            n_cell[k] = r_cell[k];
            if (CW'(k) < base) begin
                if (pop) begin
                    n_cell[k] = upstream;
                end
            end else begin
                for (int j = 0; j < BURST; j++) begin
                    if (i_push && (CW'(j) < i_push_cnt) &&
                        ((CW+1)'(base) + (CW+1)'(j) == (CW+1)'(k))) begin
                        n_cell[k] = i_burst[j];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[k] <= n_cell[k];
        end
    end
endmodule

// ----- design/stream_search_and_replace.sv -----
// Results of each accepted byte go into the result queue, whose slot 0 is the registered
// output. Throughput: one input byte per cycle while the queue has room for a full burst;
// results leave at one per cycle while the output is ready, from a 2*max(MAX_SEARCH_LEN,
// MAX_REPLACE_LEN) deep queue, so a byte that expands into N results takes N output
// transfers. Reset (synchronous, active low) empties the window and the queue and
// restores the register defaults.
module stream_search_and_replace #(
    parameter int MAX_SEARCH_LEN  = ssr_pkg::DEF_MAX_SEARCH_LEN,
    parameter int MAX_REPLACE_LEN = ssr_pkg::DEF_MAX_REPLACE_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ssr_in_if.sink                          i_in,
    ssr_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssr_pkg::CFG_W-1:0]       i_cfg_data
);
    import ssr_pkg::*;

    localparam int BURST = (MAX_SEARCH_LEN > MAX_REPLACE_LEN) ? MAX_SEARCH_LEN
                                                              : MAX_REPLACE_LEN;
    localparam int DEPTH = 2 * BURST;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int FW    = $clog2(MAX_SEARCH_LEN + 1);

    // Configuration registers.
    logic [CFG_W-1:0] r_sbytes;
    logic [LEN_W-1:0] r_slen;
    logic [CFG_W-1:0] r_rbytes;
    logic [LEN_W-1:0] r_rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbytes <= RST_SEARCH_BYTES;
            r_slen   <= RST_SEARCH_LEN;
            r_rbytes <= RST_REPLACE_BYTES;
            r_rlen   <= RST_REPLACE_LEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEARCH_BYTES:  r_sbytes <= i_cfg_data;
                CFG_SEARCH_LEN:    r_slen   <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACE_BYTES: r_rbytes <= i_cfg_data;
                CFG_REPLACE_LEN:   r_rlen   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective lengths: search length zero acts as one, both saturate at their maximum.
    logic [FW-1:0] slen;
    logic [CW-1:0] rlen;

    always_comb begin
        if (r_slen == '0) begin
            slen = FW'(1);
        end else if (r_slen > LEN_W'(MAX_SEARCH_LEN)) begin
            slen = FW'(MAX_SEARCH_LEN);
        end else begin
            slen = FW'(r_slen);
        end
    end

    always_comb begin
        if (r_rlen > LEN_W'(MAX_REPLACE_LEN)) begin
            rlen = CW'(MAX_REPLACE_LEN);
        end else begin
            rlen = CW'(r_rlen);
        end
    end

    // Input transfer and window bookkeeping.
    logic          accept;
    logic          fin;
    logic          q_room;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] fill_c;
    logic [FW-1:0] fill2;
    logic          full;
    logic          match;
    logic          shift;

    assign i_in.ready = q_room;
    assign accept     = i_in.valid & q_room;
    assign fin        = i_in.final_byte;

    assign fill_c = (r_fill >= slen) ? (slen - FW'(1)) : r_fill;
    assign fill2  = fill_c + FW'(1);
    assign full   = (fill2 == slen);

    // Row of window cells.
    logic [BYTE_W-1:0]         w_new [MAX_SEARCH_LEN];
    logic [MAX_SEARCH_LEN-1:0] cell_eq;
    logic [MAX_SEARCH_LEN-1:0] cell_used;

    for (genvar i = 0; i < MAX_SEARCH_LEN; i++) begin : g_cell
        logic [BYTE_W-1:0] next_byte;

        if (i == MAX_SEARCH_LEN - 1) begin : g_tail
            assign next_byte = w_new[i];
        end else begin : g_body
            assign next_byte = w_new[i+1];
        end

        assign cell_used[i] = (FW'(i) < slen);

        ssr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (accept),
            .i_wr        (fill_c == FW'(i)),
            .i_text_byte (i_in.text_byte),
            .i_shift     (shift),
            .i_next_byte (next_byte),
            .i_pat_byte  (r_sbytes[BYTE_W*i +: BYTE_W]),
            .o_new_byte  (w_new[i]),
            .o_match     (cell_eq[i])
        );
    end

    assign match = full & (&(cell_eq | ~cell_used));
    assign shift = full & ~match;

    // Next window fill: emptied on a match or at end of string, one short of full on a miss.
    always_comb begin
        if (fin || match) begin
            n_fill = '0;
        end else if (full) begin
            n_fill = slen - FW'(1);
        end else begin
            n_fill = fill2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_SEARCH_LEN)) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // Results of this transfer: either the replacement text or the window bytes
    // from the head, counted according to what happened to the window.
    logic [CW-1:0]         n_base;
    logic                  marker;
    logic [CW-1:0]         push_cnt;
    t_res [BURST-1:0]      burst;

    always_comb begin
        if (match) begin
            n_base = rlen;
        end else if (full) begin
            n_base = fin ? CW'(slen) : CW'(1);
        end else begin
            n_base = fin ? CW'(fill2) : '0;
        end
    end

    // An end of string with nothing to emit still sends a bare end marker.
    assign marker   = fin & (n_base == '0);
    assign push_cnt = marker ? CW'(1) : n_base;

    for (genvar j = 0; j < BURST; j++) begin : g_burst
        logic [BYTE_W-1:0] rep_byte;
        logic [BYTE_W-1:0] win_byte;

        if (j < MAX_REPLACE_LEN) begin : g_rep
            assign rep_byte = r_rbytes[BYTE_W*j +: BYTE_W];
        end else begin : g_norep
            assign rep_byte = '0;
        end

        if (j < MAX_SEARCH_LEN) begin : g_win
            assign win_byte = w_new[j];
        end else begin : g_nowin
            assign win_byte = '0;
        end

        assign burst[j].out_byte    = marker ? '0 : (match ? rep_byte : win_byte);
        assign burst[j].byte_valid  = ~marker;
        assign burst[j].string_done = fin & (push_cnt == CW'(j + 1));
    end

    // Result queue.
    t_res q_item;
    logic q_valid;

    ssr_out_queue #(
        .BURST (BURST),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_cnt  (push_cnt),
        .i_burst     (burst),
        .o_room      (q_room),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.valid       = q_valid;
    assign o_out.out_byte    = q_item.out_byte;
    assign o_out.byte_valid  = q_item.byte_valid;
    assign o_out.string_done = q_item.string_done;
endmodule

// ----- design/ssr_checker.sv -----
`include "stream_search_and_replace_defines.svh"

// Port-level checks of the search-and-replace block.
module ssr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ssr_pkg::BYTE_W-1:0]   i_out_byte,
    input logic                         i_byte_valid,
    input logic                         i_string_done
);
    import ssr_pkg::*;

    // A bare end marker always closes a string and carries a zero byte.
    `SSR_ASSERT_NOW(a_marker_closes, i_clk, i_rst_n, i_out_valid && !i_byte_valid, i_string_done && (i_out_byte == '0))

    // With the result queue empty there is always room for a new byte.
    `SSR_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // A result that is not taken stays on the output unchanged.
    `SSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_byte_valid) && $stable(i_string_done))

    // Nothing appears on the output unless a byte was transferred or results remained.
    `SSR_ASSERT_NEXT(a_no_invented, i_clk, i_rst_n, !i_out_valid && !(i_in_valid && i_in_ready), !i_out_valid)
endmodule

bind stream_search_and_replace ssr_checker u_ssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_string_done (o_out.string_done)
);

// ----- dv/testbench.sv -----
module testbench;

    import ssr_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int MAX_PAT        = DEF_MAX_SEARCH_LEN;
    localparam int MAX_REP        = DEF_MAX_REPLACE_LEN;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ssr_in_if  in_if ();
    ssr_out_if out_if ();

    stream_search_and_replace DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the block's registers and its sliding window.
    logic [CFG_W-1:0] pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic [CFG_W-1:0] rep_bytes;
    logic [LEN_W-1:0] rep_len;
    logic [7:0]       win [MAX_PAT];
    int unsigned      win_fill;

    // Rewritten bytes still owed by the block, oldest first.
    t_res expected_text[$];

    int unsigned fail_count = 0;
    bit          idle_on    = 1'b0;
    int unsigned hold_left  = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // Pattern search on one incoming byte; queues the rewritten output it causes.
    function automatic void rewrite_byte(input logic [7:0] b, input logic fin);
        int unsigned slen;
        int unsigned rlen;
        int unsigned n;
        int unsigned i;
        logic        hit;
        t_res        r;
        slen = (pat_len == 0) ? 1 : ((pat_len > MAX_PAT) ? MAX_PAT : pat_len);
        rlen = (rep_len > MAX_REP) ? MAX_REP : rep_len;
        n = 0;
        if (win_fill >= slen) win_fill = slen - 1;
        win[win_fill] = b;
        win_fill++;
        if (win_fill == slen) begin
            hit = 1'b1;
            for (i = 0; i < slen; i++) begin
                if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (i = 0; i < rlen; i++) begin
                    r = '{out_byte: rep_bytes[8*i +: 8], byte_valid: 1'b1, string_done: 1'b0};
                    expected_text.push_back(r);
                    n++;
                end
                win_fill = 0;
            end else begin
                r = '{out_byte: win[0], byte_valid: 1'b1, string_done: 1'b0};
                expected_text.push_back(r);
                n++;
                for (i = 1; i < win_fill; i++) win[i-1] = win[i];
                win_fill--;
            end
        end
        // End of string: flush the window, or emit a bare end marker.
        if (fin) begin
            for (i = 0; i < win_fill; i++) begin
                r = '{out_byte: win[i], byte_valid: 1'b1, string_done: 1'b0};
                expected_text.push_back(r);
                n++;
            end
            win_fill = 0;
            if (n == 0) begin
                r = '{out_byte: 8'h00, byte_valid: 1'b0, string_done: 1'b0};
                expected_text.push_back(r);
            end
            r = expected_text.pop_back();
            r.string_done = 1'b1;
            expected_text.push_back(r);
        end
    endfunction

    // Output ready: random stall bursts, quiet runs, and long holds on request.
    initial begin
        int unsigned stall_left;
        int unsigned run_left;
        stall_left = 0;
        run_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && run_left == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
                run_left = $urandom_range(1, 40);
            end else begin
                out_if.ready <= 1'b1;
                if (run_left > 0) run_left--;
            end
        end
    end

    // Compare every output transfer with the oldest expected byte.
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_byte: out_if.out_byte, byte_valid: out_if.byte_valid,
                    string_done: out_if.string_done};
            if (expected_text.size() == 0) begin
                if (fail_count < 10)
                    $display("ERROR: unexpected result byte %02h valid %0b done %0b",
                             got.out_byte, got.byte_valid, got.string_done);
                fail_count++;
            end else begin
                want = expected_text.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.string_done !== want.string_done) begin
                    if (fail_count < 10)
                        $display("ERROR: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 want.out_byte, want.byte_valid, want.string_done,
                                 got.out_byte, got.byte_valid, got.string_done);
                    fail_count++;
                end
            end
        end
    end

    // Offer one byte and wait for its transfer; returns on a falling edge.
    task automatic push_text(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            if (in_if.valid) in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= b;
        in_if.final_byte <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        rewrite_byte(b, fin);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected byte has come out.
    task automatic settle();
        if (in_if.valid) in_if.valid <= 1'b0;
        while (expected_text.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SEARCH_BYTES: pat_bytes = data;
            CFG_SEARCH_LEN: begin
                pat_len  = data[LEN_W-1:0];
                win_fill = 0;
            end
            CFG_REPLACE_BYTES: rep_bytes = data;
            CFG_REPLACE_LEN: rep_len = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Reset values: a zero byte is deleted, and alone it leaves a bare end marker.
    task automatic test_reset_defaults();
        push_text(8'h00, 1'b1);
        push_text(8'hFF, 1'b0);
        push_text(8'h00, 1'b1);
    endtask

    // Two-byte pattern expanded to a full replacement; oversize length saturates.
    task automatic test_expanding_replace();
        write_reg(CFG_SEARCH_BYTES, 64'hA5A5_A5A5_A5A5_6261);
        write_reg(CFG_SEARCH_LEN, 64'hFFFF_FFFF_FFFF_FFF2);
        write_reg(CFG_REPLACE_BYTES, 64'h00FF_7F80_0102_5AC3);
        write_reg(CFG_REPLACE_LEN, 64'h0000_0000_0000_000F);
        push_text("a", 1'b0);
        push_text("b", 1'b0);
        push_text("c", 1'b1);
        push_text("x", 1'b0);
        push_text("a", 1'b0);
        push_text("b", 1'b1);
        push_text("a", 1'b1);
    endtask

    // A search length of zero acts as one.
    task automatic test_single_byte_pattern();
        write_reg(CFG_SEARCH_BYTES, 64'h0000_0000_0000_0041);
        write_reg(CFG_SEARCH_LEN, 64'h0);
        push_text("A", 1'b0);
        push_text("B", 1'b1);
    endtask

    // Held bytes vanish when the search length is rewritten; a deleted full
    // pattern on the last byte leaves a bare end marker.
    task automatic test_length_change_drop();
        write_reg(CFG_SEARCH_BYTES, 64'h4847_4645_4443_4241);
        write_reg(CFG_SEARCH_LEN, 64'hF);
        write_reg(CFG_REPLACE_LEN, 64'h0);
        push_text("A", 1'b0);
        push_text("B", 1'b0);
        push_text("C", 1'b0);
        write_reg(CFG_SEARCH_LEN, 64'h8);
        push_text("X", 1'b1);
        for (int i = 0; i < MAX_PAT; i++) push_text(8'(8'h41 + i), i == MAX_PAT - 1);
    endtask

    // Every byte expands to eight while the output is held off, so the input stalls.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        write_reg(CFG_SEARCH_BYTES, 64'h0000_0000_0000_007A);
        write_reg(CFG_SEARCH_LEN, 64'h1);
        write_reg(CFG_REPLACE_BYTES, {$urandom, $urandom});
        write_reg(CFG_REPLACE_LEN, 64'h8);
        for (int pass = 0; pass < 2; pass++) begin
            hold_left = 120;
            for (int i = 0; i < 20; i++) push_text(8'h7A, i % 10 == 9);
            settle();
        end
    endtask

    // New random register settings; pattern bytes mostly from a small alphabet.
    task automatic pick_setting();
        logic [CFG_W-1:0] pat;
        logic [CFG_W-1:0] len_word;
        int unsigned      r;
        bit               narrow;
        narrow = $urandom_range(0, 3) != 0;
        for (int i = 0; i < MAX_PAT; i++)
            pat[8*i +: 8] = narrow ? 8'($urandom_range(8'h61, 8'h63)) : 8'($urandom);
        write_reg(CFG_SEARCH_BYTES, pat);
        if ($urandom_range(0, 5) != 0) begin
            len_word = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            len_word[LEN_W-1:0] = (r == 0) ? 4'd0 :
                                  (r == 1) ? 4'($urandom_range(MAX_PAT + 1, 15)) :
                                             4'($urandom_range(1, MAX_PAT));
            write_reg(CFG_SEARCH_LEN, len_word);
        end
        if ($urandom_range(0, 2) != 0) write_reg(CFG_REPLACE_BYTES, {$urandom, $urandom});
        if ($urandom_range(0, 2) != 0) begin
            len_word = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            len_word[LEN_W-1:0] = (r == 0) ? 4'($urandom_range(MAX_REP + 1, 15)) :
                                             4'($urandom_range(0, MAX_REP));
            write_reg(CFG_REPLACE_LEN, len_word);
        end
    endtask

    // Random strings built mostly from whole patterns, with broken prefixes and noise.
    task automatic test_random_text(input int unsigned n_items, input bit with_idle);
        int unsigned sent;
        int unsigned slen;
        int unsigned want_len;
        int unsigned r;
        logic [7:0]  text[$];
        idle_on = with_idle;
        sent = 0;
        while (sent < n_items) begin
            pick_setting();
            slen = (pat_len == 0) ? 1 : ((pat_len > MAX_PAT) ? MAX_PAT : pat_len);
            repeat ($urandom_range(2, 5)) begin
                text.delete();
                want_len = $urandom_range(1, 24);
                while (text.size() < want_len) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        for (int i = 0; i < slen; i++) text.push_back(pat_bytes[8*i +: 8]);
                    end else if (r == 4) begin
                        for (int i = 0; i < $urandom_range(1, slen); i++)
                            text.push_back(pat_bytes[8*i +: 8]);
                    end else if (r == 5) begin
                        text.push_back(8'($urandom));
                    end else begin
                        text.push_back(pat_bytes[8*$urandom_range(0, slen - 1) +: 8]);
                    end
                end
                foreach (text[i]) push_text(text[i], i == text.size() - 1);
                sent += text.size();
            end
            // Now and then leave a string open across the next register change.
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    push_text(8'($urandom), 1'b0);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence.
    initial begin
        in_if.valid      = 1'b0;
        in_if.text_byte  = '0;
        in_if.final_byte = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        pat_bytes = RST_SEARCH_BYTES;
        pat_len   = RST_SEARCH_LEN;
        rep_bytes = RST_REPLACE_BYTES;
        rep_len   = RST_REPLACE_LEN;
        win_fill  = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_expanding_replace();
        test_single_byte_pattern();
        test_length_change_drop();
        test_output_backpressure();
        test_random_text(180, 1'b1);
        test_random_text(30, 1'b0);

        // Drain, then give any stray output time to show up.
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_text.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
